@@ rtl/core/ppsa_pkg.sv @@
// ----------------------------------------------------------------------------
// Physical page stack allocator package
// Shared constants, codes and controller/datapath types.
// ----------------------------------------------------------------------------
package ppsa_pkg;

    localparam int STACK_DEPTH = 65536;
    localparam int PAGE_BYTES  = 4096;
    localparam int ADDR_W      = 32;
    localparam int BASE_W      = 64;
    localparam int TYPE_W      = 32;
    localparam int FILL_W      = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W       = $clog2(STACK_DEPTH);
    localparam int PAGE_SHIFT  = $clog2(PAGE_BYTES);
    localparam int COUNT_W     = BASE_W - PAGE_SHIFT;
    localparam int KSTART_W    = ADDR_W - PAGE_SHIFT + 1;

    localparam logic [1:0] KIND_REGION = 2'd0;
    localparam logic [1:0] KIND_FREE   = 2'd1;
    localparam logic [1:0] KIND_ALLOC  = 2'd2;

    localparam logic [TYPE_W-1:0] TYPE_AVAILABLE = TYPE_W'(1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP_A,
        ST_PREP_B,
        ST_WALK,
        ST_ALLOC
    } state_t;

    typedef struct packed {
        logic load_region;
        logic prep_a;
        logic prep_b;
        logic walk_push;
        logic push_free;
        logic pop;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic walk_done;
        logic out_busy;
    } stat_t;

endpackage

@@ rtl/core/ppsa_if.sv @@
// ----------------------------------------------------------------------------
// Physical page stack allocator channels
// Request, response and configuration channels with valid/ready transfers.
// ----------------------------------------------------------------------------
interface ppsa_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [63:0] region_base;
    logic [63:0] region_length;
    logic [31:0] region_type;
    logic [31:0] freed_frame;

    modport source (output valid, kind, region_base, region_length, region_type,
                    freed_frame, input ready);
    modport sink (input valid, kind, region_base, region_length, region_type,
                  freed_frame, output ready);
endinterface

interface ppsa_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] allocated_frame;
    logic [16:0] free_count;

    modport source (output valid, allocated_frame, free_count, input ready);
    modport sink (input valid, allocated_frame, free_count, output ready);
endinterface

interface ppsa_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

@@ rtl/core/ppsa_ctrl.sv @@
// ----------------------------------------------------------------------------
// Physical page stack allocator controller
// Sequences request decode, region walk setup, the page walk and the pop.
// ----------------------------------------------------------------------------
module ppsa_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    input  logic [1:0]     req_kind,
    output logic           req_ready,
    input  ppsa_pkg::stat_t stat,
    output ppsa_pkg::cmd_t  cmd
);
    import ppsa_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    unique case (req_kind)
                        KIND_REGION: state_next = ST_PREP_A;
                        KIND_ALLOC:  state_next = ST_ALLOC;
                        default:     state_next = ST_IDLE;
                    endcase
                end
            end
            ST_PREP_A: state_next = ST_PREP_B;
            ST_PREP_B: state_next = ST_WALK;
            ST_WALK:
            begin
                if (stat.walk_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_ALLOC:
            begin
                if (!stat.out_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        req_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    unique case (req_kind)
                        KIND_REGION: cmd.load_region = 1'b1;
                        KIND_FREE:   cmd.push_free   = 1'b1;
                        KIND_ALLOC:  cmd.pop         = 1'b1;
                        default:     cmd             = '0;
                    endcase
                end
            end
            ST_PREP_A: cmd.prep_a    = 1'b1;
            ST_PREP_B: cmd.prep_b    = 1'b1;
            ST_WALK:   cmd.walk_push = !stat.walk_done;
            ST_ALLOC:  cmd.load_out  = !stat.out_busy;
            default:   cmd           = '0;
        endcase
    end

endmodule

@@ rtl/core/ppsa_dp.sv @@
// ----------------------------------------------------------------------------
// Physical page stack allocator datapath
// Frame stack memory, fill counter, region walk registers and result register.
// ----------------------------------------------------------------------------
module ppsa_dp
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  ppsa_pkg::cmd_t                  cmd,
    output ppsa_pkg::stat_t                 stat,
    input  logic [ppsa_pkg::BASE_W-1:0]     region_base,
    input  logic [ppsa_pkg::BASE_W-1:0]     region_length,
    input  logic [ppsa_pkg::TYPE_W-1:0]     region_type,
    input  logic [ppsa_pkg::ADDR_W-1:0]     freed_frame,
    input  logic                            cfg_valid,
    input  logic [ppsa_pkg::ADDR_W-1:0]     cfg_data,
    output logic                            rsp_valid,
    input  logic                            rsp_ready,
    output logic [ppsa_pkg::ADDR_W-1:0]     rsp_frame,
    output logic [ppsa_pkg::FILL_W-1:0]     rsp_count
);
    import ppsa_pkg::*;

    localparam logic [ADDR_W:0] PAGE_MASK = (ADDR_W + 1)'(PAGE_BYTES - 1);

    logic [ADDR_W-1:0]   kend_reg;
    logic [FILL_W-1:0]   fill_reg;
    logic [FILL_W-1:0]   fill_next;
    logic [ADDR_W:0]     first_reg;
    logic [ADDR_W:0]     addr_reg;
    logic [COUNT_W-1:0]  count_reg;
    logic [COUNT_W-1:0]  rem_reg;
    logic [KSTART_W-1:0] kstart_reg;
    logic                elig_reg;
    logic [ADDR_W-1:0]   mem [STACK_DEPTH];
    logic [ADDR_W-1:0]   rd_data_reg;
    logic                pop_hit_reg;
    logic                out_valid_reg;
    logic [ADDR_W-1:0]   out_frame_reg;
    logic [FILL_W-1:0]   out_count_reg;

    logic                full;
    logic                empty;
    logic [ADDR_W:0]     first_calc;
    logic                elig_calc;
    logic [BASE_W-1:0]   len_m1;
    logic                above;
    logic [ADDR_W-1:0]   diff;
    logic [KSTART_W-1:0] kstart_calc;
    logic [ADDR_W:0]     addr_calc;
    logic [COUNT_W-1:0]  kstart_ext;
    logic [COUNT_W-1:0]  rem_calc;
    logic                wr_en;
    logic [ADDR_W-1:0]   wr_data;
    logic [FILL_W-1:0]   fill_m1;

    assign full  = (fill_reg == FILL_W'(STACK_DEPTH));
    assign empty = (fill_reg == '0);

    assign first_calc = ({1'b0, region_base[ADDR_W-1:0]} + PAGE_MASK) & ~PAGE_MASK;
    assign elig_calc  = (region_type == TYPE_AVAILABLE)
                        && (region_base[BASE_W-1:ADDR_W] == '0)
                        && (region_length > BASE_W'(PAGE_BYTES));
    assign len_m1     = region_length - BASE_W'(1);

    assign above       = (first_reg > {1'b0, kend_reg});
    assign diff        = kend_reg - first_reg[ADDR_W-1:0];
    assign kstart_calc = above ? '0
                         : ({1'b0, diff[ADDR_W-1:PAGE_SHIFT]} + KSTART_W'(1));
    assign addr_calc   = above ? first_reg
                         : (first_reg + {1'b0, diff[ADDR_W-1:PAGE_SHIFT], PAGE_SHIFT'(0)}
                            + (ADDR_W + 1)'(PAGE_BYTES));

    assign kstart_ext = COUNT_W'(kstart_reg);
    assign rem_calc   = (elig_reg && (count_reg > kstart_ext)) ? (count_reg - kstart_ext) : '0;

    assign stat.walk_done = (rem_reg == '0) || full || addr_reg[ADDR_W];
    assign stat.out_busy  = out_valid_reg && !rsp_ready;

    assign wr_en   = (cmd.walk_push || cmd.push_free) && !full;
    assign wr_data = cmd.walk_push ? addr_reg[ADDR_W-1:0] : freed_frame;
    assign fill_m1 = fill_reg - FILL_W'(1);

    always_comb
    begin
        fill_next = fill_reg;
        if (wr_en)
        begin
            fill_next = fill_reg + FILL_W'(1);
        end
        else if (cmd.pop && !empty)
        begin
            fill_next = fill_m1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kend_reg      <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                kend_reg <= cfg_data;
            end
            fill_reg <= fill_next;
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_region)
        begin
            first_reg <= first_calc;
            count_reg <= len_m1[BASE_W-1:PAGE_SHIFT];
            elig_reg  <= elig_calc;
        end
        if (cmd.prep_a)
        begin
            kstart_reg <= kstart_calc;
            addr_reg   <= addr_calc;
        end
        else if (cmd.walk_push)
        begin
            addr_reg <= addr_reg + (ADDR_W + 1)'(PAGE_BYTES);
        end
        if (cmd.prep_b)
        begin
            rem_reg <= rem_calc;
        end
        else if (cmd.walk_push)
        begin
            rem_reg <= rem_reg - COUNT_W'(1);
        end
        if (cmd.load_out)
        begin
            out_frame_reg <= pop_hit_reg ? rd_data_reg : '0;
            out_count_reg <= fill_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[fill_reg[IDX_W-1:0]] <= wr_data;
        end
        if (cmd.pop)
        begin
            rd_data_reg <= mem[fill_m1[IDX_W-1:0]];
            pop_hit_reg <= !empty;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_frame = out_frame_reg;
    assign rsp_count = out_count_reg;

endmodule

@@ rtl/core/physical_page_stack_allocator_core.sv @@
// A free pushes its frame at the transfer; the request side is ready again on the next cycle.
// An allocate reads the stack memory into a read register, then loads the result
// register, and blocks new requests until the result register is free.
// A region is loaded, set up in PREP_A and PREP_B, then pushes its pages (page walk).
// Reset clears the fill count, the kernel end register and the controller;
// stack contents are undefined until written and need no clearing pass.
// ----------------------------------------------------------------------------
// Physical page stack allocator core
// LIFO stack of free page-frame addresses with region load, free and allocate.
// ----------------------------------------------------------------------------
module physical_page_stack_allocator_core
(
    input  logic       clk,
    input  logic       rst_n,
    ppsa_req_if.sink   req,
    ppsa_rsp_if.source rsp,
    ppsa_cfg_if.sink   cfg
);
    import ppsa_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    assign cfg.ready = 1'b1;

    ppsa_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_kind  (req.kind),
        .req_ready (req.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    ppsa_dp u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .region_base   (req.region_base),
        .region_length (req.region_length),
        .region_type   (req.region_type),
        .freed_frame   (req.freed_frame),
        .cfg_valid     (cfg.valid),
        .cfg_data      (cfg.data),
        .rsp_valid     (rsp.valid),
        .rsp_ready     (rsp.ready),
        .rsp_frame     (rsp.allocated_frame),
        .rsp_count     (rsp.free_count)
    );

endmodule

@@ rtl/core/ppsa_checker.sv @@
// ----------------------------------------------------------------------------
// Physical page stack allocator checker
// Port-level assertions on transfers, bound to the core.
// ----------------------------------------------------------------------------
module ppsa_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic [1:0]  req_kind,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [31:0] rsp_frame,
    input logic [16:0] rsp_count
);
    import ppsa_pkg::*;

    logic req_xfer;

    assign req_xfer = req_valid && req_ready;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("Response valid dropped before its transfer.");

    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp_frame) && $stable(rsp_count))
        else $error("Response payload changed while stalled.");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_count <= 17'(STACK_DEPTH))
        else $error("Free count exceeds the stack depth.");

    a_alloc_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_xfer && (req_kind == KIND_ALLOC) |=> !req_ready)
        else $error("Request accepted while an allocate is in progress.");

    a_region_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_xfer && (req_kind == KIND_REGION) |=> !req_ready ##1 !req_ready)
        else $error("Request accepted during region setup.");

endmodule

bind physical_page_stack_allocator_core ppsa_checker u_ppsa_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .req_kind  (req.kind),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_frame (rsp.allocated_frame),
    .rsp_count (rsp.free_count)
);

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Physical page stack allocator testbench
// Drives region, free and allocate requests into the allocator core through
// its valid/ready channels. The kernel end register changes between phases.
// Every popped frame and fill count is checked against a behavioral copy of
// the free-frame stack, or a directed row's values. A short table of directed
// requests runs first, followed by random phases with sender and receiver
// idling and one long receiver hold-off. A closing table fills the stack to overflow.
// ----------------------------------------------------------------------------
module tb_top;
    import ppsa_pkg::*;

    localparam logic [1:0]  KIND_IGNORED    = 2'd3;
    localparam bit [63:0]   PAGE_SPAN       = 64'(PAGE_BYTES);
    localparam bit [63:0]   FRAME_ADDR_MAX  = 64'hFFFF_FFFF;
    localparam int          SETTLE_BASE     = 8;
    localparam int          RSP_HOLD_CYCLES = 400;
    localparam int          WATCHDOG_LIMIT  = 400000;
    localparam int          NUM_PHASES      = 7;
    localparam int          ITEMS_PER_PHASE = 250;
    localparam int          PRESSURE_PHASE  = 4;
    localparam int          SEND_IDLE_PCT [NUM_PHASES] = '{0, 81, 0, 15, 0, 81, 0};
    localparam int          RSP_STALL_PCT [NUM_PHASES] = '{0, 0, 81, 15, 0, 15, 81};

    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] base;
        logic [63:0] length;
        logic [31:0] rtype;
        logic [31:0] frame;
    } page_req_t;

    typedef struct packed {
        logic [31:0]       frame;
        logic [FILL_W-1:0] count;
    } alloc_rsp_t;

    typedef enum logic {
        ROW_REQUEST,
        ROW_KERNEL_END
    } row_op_t;

    typedef struct packed {
        row_op_t     op;
        page_req_t   req;
        logic        fixed;
        alloc_rsp_t  want;
        logic [31:0] kernel_end;
    } stim_row_t;

    logic clk;
    logic rst_n;

    ppsa_req_if req_ch ();
    ppsa_rsp_if rsp_ch ();
    ppsa_cfg_if cfg_ch ();

    physical_page_stack_allocator_core u_dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    bit [31:0]   free_frames [STACK_DEPTH];
    int unsigned free_depth;
    bit [31:0]   kernel_end;
    alloc_rsp_t  alloc_expect_q [$];
    stim_row_t   stim_rows [$];
    int          err_count;
    int          settle_cycles;
    int          send_idle_pct;
    int          rsp_stall_pct;
    bit          hold_pending;
    alloc_rsp_t  got_rsp;
    alloc_rsp_t  want_rsp;

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    function automatic void stack_push(input bit [31:0] addr);
        if (free_depth < STACK_DEPTH)
        begin
            free_frames[free_depth] = addr;
            free_depth++;
        end
    endfunction

    // Applies one request to the frame stack and returns the number of region pages pushed.
    function automatic int unsigned model_request(input page_req_t it, output bit produced,
                                                  output alloc_rsp_t res);
        int unsigned pushed;
        bit [63:0]   first;
        bit [63:0]   count;
        bit [63:0]   k;
        bit [63:0]   kend;
        bit [63:0]   addr;
        pushed   = 0;
        produced = 1'b0;
        res      = '0;
        case (it.kind)
            KIND_REGION:
            begin
                if (it.rtype == TYPE_AVAILABLE && it.base <= FRAME_ADDR_MAX &&
                    it.length > PAGE_SPAN)
                begin
                    first = ((it.base + PAGE_SPAN - 1) / PAGE_SPAN) * PAGE_SPAN;
                    count = (it.length - 1) / PAGE_SPAN;
                    kend  = {32'd0, kernel_end};
                    k     = (first > kend) ? 64'd0 : (kend - first) / PAGE_SPAN + 1;
                    while (k < count && free_depth < STACK_DEPTH)
                    begin
                        addr = first + k * PAGE_SPAN;
                        if (addr > FRAME_ADDR_MAX)
                            break;
                        stack_push(addr[31:0]);
                        pushed++;
                        k++;
                    end
                end
            end
            KIND_FREE:
                stack_push(it.frame);
            KIND_ALLOC:
            begin
                produced = 1'b1;
                if (free_depth > 0)
                begin
                    free_depth--;
                    res.frame = free_frames[free_depth];
                end
                res.count = FILL_W'(free_depth);
            end
            default:
                ;
        endcase
        return pushed;
    endfunction

    function automatic page_req_t random_request();
        page_req_t   it;
        int unsigned roll;
        int unsigned alloc_pct;
        longint      near;
        it.kind   = KIND_FREE;
        it.base   = {$urandom, $urandom};
        it.length = {$urandom, $urandom};
        it.rtype  = $urandom;
        it.frame  = $urandom;
        roll      = $urandom_range(99);
        alloc_pct = (free_depth > 48) ? 60 : 35;
        if (roll < 4)
            it.kind = KIND_IGNORED;
        else if (roll < 8)
            it.kind = KIND_REGION;
        else if (roll < 8 + alloc_pct)
            it.kind = KIND_ALLOC;
        else if (roll < 30 + alloc_pct)
        begin
            it.kind  = KIND_REGION;
            it.rtype = ($urandom_range(99) < 88) ? TYPE_AVAILABLE : 32'($urandom);
            case ($urandom_range(3))
                0: it.base = {32'd0, $urandom} & ~64'hFFF;
                1: it.base = {32'd0, $urandom};
                default:
                begin
                    near = longint'({32'd0, kernel_end}) + longint'($urandom_range(20 * 4096))
                           - 16 * 4096;
                    if (near < 0)
                        near = 0;
                    if (near > longint'(FRAME_ADDR_MAX))
                        near = longint'(FRAME_ADDR_MAX);
                    it.base = 64'(near);
                    if ($urandom_range(1) == 1)
                        it.base[11:0] = '0;
                end
            endcase
            if ($urandom_range(99) < 5)
                it.base[63:32] = $urandom | 32'd1;
            it.length = 64'($urandom_range(24)) * PAGE_SPAN +
                        (($urandom_range(3) == 0) ? 64'd0 : 64'($urandom_range(4095)));
        end
        return it;
    endfunction

    task automatic send_request(input page_req_t it, input bit fixed, input alloc_rsp_t want);
        bit          produced;
        alloc_rsp_t  res;
        int unsigned pushed;
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.kind          <= it.kind;
        req_ch.region_base   <= it.base;
        req_ch.region_length <= it.length;
        req_ch.region_type   <= it.rtype;
        req_ch.freed_frame   <= it.frame;
        do
            @(posedge clk);
        while (!req_ch.ready);
        pushed = model_request(it, produced, res);
        if (produced)
            alloc_expect_q.push_back(fixed ? want : res);
        settle_cycles = SETTLE_BASE + int'(pushed);
    endtask

    task automatic write_kernel_end(input bit [31:0] value);
        req_ch.valid <= 1'b0;
        while (alloc_expect_q.size() != 0)
            @(posedge clk);
        repeat (settle_cycles)
            @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        kernel_end = value;
    endtask

    task automatic add_row(input logic [1:0] kind, input logic [63:0] base,
                           input logic [63:0] length, input logic [31:0] rtype,
                           input logic [31:0] frame);
        stim_row_t row;
        row     = '0;
        row.op  = ROW_REQUEST;
        row.req = '{kind: kind, base: base, length: length, rtype: rtype, frame: frame};
        stim_rows.push_back(row);
    endtask

    task automatic add_checked_alloc(input logic [31:0] frame, input logic [FILL_W-1:0] count);
        stim_row_t row;
        row          = '0;
        row.op       = ROW_REQUEST;
        row.req.kind = KIND_ALLOC;
        row.fixed    = 1'b1;
        row.want     = '{frame: frame, count: count};
        stim_rows.push_back(row);
    endtask

    task automatic add_kernel_end(input logic [31:0] value);
        stim_row_t row;
        row            = '0;
        row.op         = ROW_KERNEL_END;
        row.kernel_end = value;
        stim_rows.push_back(row);
    endtask

    task automatic run_rows(input int first, input int last);
        for (int i = first; i <= last; i++)
        begin
            if (stim_rows[i].op == ROW_KERNEL_END)
                write_kernel_end(stim_rows[i].kernel_end);
            else
                send_request(stim_rows[i].req, stim_rows[i].fixed, stim_rows[i].want);
        end
    endtask

    always @(posedge clk)
    begin
        if (rsp_ch.valid && rsp_ch.ready)
        begin
            got_rsp = '{frame: rsp_ch.allocated_frame, count: rsp_ch.free_count};
            if (alloc_expect_q.size() == 0)
            begin
                $error("unexpected allocate transfer: frame %h, count %0d",
                       got_rsp.frame, got_rsp.count);
                err_count++;
            end
            else
            begin
                want_rsp = alloc_expect_q.pop_front();
                if (got_rsp.frame !== want_rsp.frame)
                begin
                    $error("allocated_frame mismatch: expected %h, actual %h",
                           want_rsp.frame, got_rsp.frame);
                    err_count++;
                end
                if (got_rsp.count !== want_rsp.count)
                begin
                    $error("free_count mismatch: expected %0d, actual %0d",
                           want_rsp.count, got_rsp.count);
                    err_count++;
                end
            end
        end
    end

    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_pending)
            begin
                hold_pending = 1'b0;
                rsp_ch.ready <= 1'b0;
                repeat (RSP_HOLD_CYCLES - 1)
                    @(posedge clk);
            end
            else
                rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
        end
    end

    initial
    begin
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("tb_top: done, errors");
        $finish;
    end

    initial
    begin
        bit [31:0] phase_kend [NUM_PHASES];
        page_req_t it;
        int        closing_first;
        int        sent;

        rst_n                = 1'b0;
        req_ch.valid         = 1'b0;
        req_ch.kind          = KIND_REGION;
        req_ch.region_base   = '0;
        req_ch.region_length = '0;
        req_ch.region_type   = '0;
        req_ch.freed_frame   = '0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.data          = '0;
        free_depth           = 0;
        kernel_end           = '0;
        err_count            = 0;
        settle_cycles        = SETTLE_BASE;
        send_idle_pct        = 0;
        rsp_stall_pct        = 0;
        hold_pending         = 1'b0;

        add_checked_alloc(32'h0000_0000, 17'd0);
        add_row(KIND_FREE, 64'd0, 64'd0, 32'd0, 32'h0000_0000);
        add_row(KIND_FREE, 64'd0, 64'd0, 32'd0, 32'hFFFF_FFFF);
        add_checked_alloc(32'hFFFF_FFFF, 17'd1);
        add_checked_alloc(32'h0000_0000, 17'd0);
        add_checked_alloc(32'h0000_0000, 17'd0);
        add_row(KIND_REGION, 64'd0, 64'd4096, TYPE_AVAILABLE, 32'd0);
        add_row(KIND_REGION, 64'd0, 64'd4097, TYPE_AVAILABLE, 32'd0);
        add_row(KIND_REGION, 64'h1001, 64'(3 * 4096 + 1), TYPE_AVAILABLE, 32'd0);
        add_checked_alloc(32'h0000_4000, 17'd2);
        add_row(KIND_REGION, 64'h1_0000, 64'h1_0000, 32'd2, 32'd0);
        add_row(KIND_REGION, 64'h1_0000_0000, 64'h1_0000, TYPE_AVAILABLE, 32'd0);
        add_row(KIND_REGION, 64'hFFFF_C000, 64'hFFFF_FFFF_FFFF_FFFF, TYPE_AVAILABLE, 32'd0);
        add_checked_alloc(32'hFFFF_F000, 17'd5);
        add_row(KIND_IGNORED, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_checked_alloc(32'hFFFF_E000, 17'd4);
        add_kernel_end(32'h0010_0000);
        add_row(KIND_REGION, 64'h000F_E000, 64'h6000, TYPE_AVAILABLE, 32'd0);
        add_checked_alloc(32'h0010_2000, 17'd5);
        add_kernel_end(32'hFFFF_FFFF);
        add_row(KIND_REGION, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF, TYPE_AVAILABLE, 32'd0);
        add_checked_alloc(32'h0010_1000, 17'd4);
        add_row(KIND_FREE, 64'd0, 64'd0, 32'd0, 32'h5A5A_A5A5);
        add_checked_alloc(32'h5A5A_A5A5, 17'd4);
        closing_first = stim_rows.size();
        add_kernel_end(32'h0FFF_FFFF);
        add_row(KIND_REGION, 64'h1000_0000, 64'h2000_0000, TYPE_AVAILABLE, 32'd0);
        add_row(KIND_FREE, 64'd0, 64'd0, 32'd0, 32'hDEAD_BEEF);
        add_row(KIND_REGION, 64'h4000_0000, 64'h1_0000, TYPE_AVAILABLE, 32'd0);
        add_row(KIND_ALLOC, 64'd0, 64'd0, 32'd0, 32'd0);
        add_row(KIND_FREE, 64'd0, 64'd0, 32'd0, 32'h1234_5678);
        add_row(KIND_FREE, 64'd0, 64'd0, 32'd0, 32'h8765_4321);
        add_checked_alloc(32'h1234_5678, 17'd65535);

        phase_kend[0] = 32'h0000_0000;
        phase_kend[1] = 32'hFFFF_FFFF;
        phase_kend[2] = $urandom;
        phase_kend[3] = $urandom & 32'hFFFF_F000;
        phase_kend[4] = 32'h0010_0000;
        phase_kend[5] = $urandom;
        phase_kend[6] = 32'h8000_0000;

        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_rows(0, closing_first - 1);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_kernel_end(phase_kend[p]);
            send_idle_pct = SEND_IDLE_PCT[p];
            rsp_stall_pct = RSP_STALL_PCT[p];
            if (p == PRESSURE_PHASE)
                hold_pending = 1'b1;
            sent = 0;
            while (sent < ITEMS_PER_PHASE)
            begin
                it = random_request();
                send_request(it, 1'b0, '0);
                if (it.kind != KIND_IGNORED)
                    sent++;
            end
        end

        send_idle_pct = 0;
        rsp_stall_pct = 15;
        run_rows(closing_first, stim_rows.size() - 1);

        req_ch.valid <= 1'b0;
        while (alloc_expect_q.size() != 0)
            @(posedge clk);
        repeat (settle_cycles)
            @(posedge clk);
        if (err_count == 0 && alloc_expect_q.size() == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end
endmodule
